[hdl/cdrb_pkg.sv]
// ----------------------------------------------------------------------------
// cdrb_pkg
// Shared types and codes for the circular deque ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package cdrb_pkg;

    // Field widths fixed by the stream format
    localparam int ACTION_W  = 2;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 32;  // value
    localparam int S_TUSER_W = 8;   // action, zero filled to a byte
    localparam int M_TDATA_W = 32;  // popped_value
    localparam int M_TUSER_W = 8;   // status, is_empty, is_full, zero filled

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED     = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY      = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic step;     // execute the beat on the input channel
        logic hold;     // result on show, keep pointers and read data
    } cdrb_cmd_t;

endpackage

`default_nettype wire

[hdl/cdrb_ram.sv]
// ----------------------------------------------------------------------------
// cdrb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/cdrb_ctrl.sv]
// ----------------------------------------------------------------------------
// cdrb_ctrl
// Handshake controller: takes one beat, then shows its result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrb_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output cdrb_pkg::cdrb_cmd_t      cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_OUT  = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign cmd.step = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.hold = (state_reg == ST_OUT);

endmodule

`default_nettype wire

[hdl/cdrb_datapath.sv]
// ----------------------------------------------------------------------------
// cdrb_datapath
// Head/tail pointers, empty flag, slot memory and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrb_datapath #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire cdrb_pkg::cdrb_cmd_t                cmd,
    input  wire logic [cdrb_pkg::ACTION_W-1:0]      action,
    input  wire logic [cdrb_pkg::VALUE_W-1:0]       value,
    output logic      [cdrb_pkg::VALUE_W-1:0]       popped_value,
    output logic      [cdrb_pkg::STATUS_W-1:0]      status,
    output logic                                    is_empty,
    output logic                                    is_full
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);
    localparam logic [AW-1:0] IDX_ZERO = '0;

    logic [AW-1:0]               head_reg, head_next;
    logic [AW-1:0]               tail_reg, tail_next;
    logic                        empty_reg, empty_next;
    logic [cdrb_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                        pop_ok_reg, pop_ok_next;

    logic [AW-1:0]         tail_inc, head_inc, head_dec;
    logic                  full_now;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

    // wrap without a modulo so any depth works
    assign tail_inc = (tail_reg == IDX_LAST) ? IDX_ZERO : tail_reg + AW'(1);
    assign head_inc = (head_reg == IDX_LAST) ? IDX_ZERO : head_reg + AW'(1);
    assign head_dec = (head_reg == IDX_ZERO) ? IDX_LAST : head_reg - AW'(1);
    assign full_now = !empty_reg && (tail_inc == head_reg);

    generate
        if (DATA_WIDTH <= cdrb_pkg::VALUE_W) begin : g_narrow
            assign ram_wdata = value[DATA_WIDTH-1:0];
        end else begin : g_wide
            assign ram_wdata = {{(DATA_WIDTH - cdrb_pkg::VALUE_W){1'b0}}, value};
        end
    endgenerate

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        ram_we      = 1'b0;
        ram_waddr   = IDX_ZERO;
        ram_re      = 1'b0;
        if (cmd.step) begin
            status_next = cdrb_pkg::STS_DONE;
            pop_ok_next = 1'b0;
            unique case (action)
                cdrb_pkg::ACT_PUSH_BACK, cdrb_pkg::ACT_PUSH_FRONT: begin
                    priority if (full_now) begin
                        status_next = cdrb_pkg::STS_FULL;
                    end else if (empty_reg) begin
                        // first entry always lands in slot zero
                        head_next  = IDX_ZERO;
                        tail_next  = IDX_ZERO;
                        empty_next = 1'b0;
                        ram_we     = 1'b1;
                        ram_waddr  = IDX_ZERO;
                    end else if (action == cdrb_pkg::ACT_PUSH_BACK) begin
                        tail_next = tail_inc;
                        ram_we    = 1'b1;
                        ram_waddr = tail_inc;
                    end else begin
                        head_next = head_dec;
                        ram_we    = 1'b1;
                        ram_waddr = head_dec;
                    end
                end
                cdrb_pkg::ACT_POP_FRONT: begin
                    if (empty_reg) begin
                        status_next = cdrb_pkg::STS_EMPTY;
                    end else begin
                        ram_re      = 1'b1;
                        pop_ok_next = 1'b1;
                        if (head_reg == tail_reg) begin
                            head_next  = IDX_ZERO;
                            tail_next  = IDX_ZERO;
                            empty_next = 1'b1;
                        end else begin
                            head_next = head_inc;
                        end
                    end
                end
                cdrb_pkg::ACT_UNUSED: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= IDX_ZERO;
            tail_reg   <= IDX_ZERO;
            empty_reg  <= 1'b1;
            status_reg <= cdrb_pkg::STS_DONE;
            pop_ok_reg <= 1'b0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            empty_reg  <= empty_next;
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    // read address is the head before the pop updates it
    cdrb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re && !cmd.hold),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    generate
        if (DATA_WIDTH >= cdrb_pkg::VALUE_W) begin : g_out_trunc
            assign popped_value = pop_ok_reg ? ram_rdata[cdrb_pkg::VALUE_W-1:0] : '0;
        end else begin : g_out_ext
            assign popped_value = pop_ok_reg ?
                {{(cdrb_pkg::VALUE_W - DATA_WIDTH){1'b0}}, ram_rdata} : '0;
        end
    endgenerate

    assign status   = status_reg;
    assign is_empty = empty_reg;
    assign is_full  = full_now;

endmodule

`default_nettype wire

[hdl/circular_deque_ring_buffer_unit.sv]
// ----------------------------------------------------------------------------
// circular_deque_ring_buffer_unit
// Fixed-depth deque: push at back, push at front, pop from front.
// ----------------------------------------------------------------------------
//  channel | dir | tdata           | tuser
//  s_      | in  | [31:0] value    | [1:0] action
//  m_      | out | [31:0] popped   | [1:0] status, [2] is_empty, [3] is_full
//
//  Each beat is accepted, then its result is on show from the next cycle.
//  Pop data comes from the registered read of the slot RAM. The next beat
//  is taken the cycle after the result is taken.
//  Synchronous active-low reset empties the deque; slots are not cleared.
//  m_tready low holds the result and keeps s_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque_ring_buffer_unit #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [cdrb_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] value
    input  wire logic [cdrb_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] action
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [cdrb_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] popped_value
    output logic      [cdrb_pkg::M_TUSER_W-1:0] m_tuser   // [1:0] status, [2] is_empty,
                                                          // [3] is_full
);

    cdrb_pkg::cdrb_cmd_t                cmd;
    logic [cdrb_pkg::VALUE_W-1:0]       popped_value;
    logic [cdrb_pkg::STATUS_W-1:0]      status;
    logic                               is_empty;
    logic                               is_full;
    logic [cdrb_pkg::S_TUSER_W-1:0]     unused_tuser;

    assign unused_tuser = s_tuser;

    cdrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    cdrb_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .action       (unused_tuser[cdrb_pkg::ACTION_W-1:0]),
        .value        (s_tdata[cdrb_pkg::VALUE_W-1:0]),
        .popped_value (popped_value),
        .status       (status),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    assign m_tdata = popped_value;
    assign m_tuser = {{(cdrb_pkg::M_TUSER_W - cdrb_pkg::STATUS_W - 2){1'b0}},
                      is_full, is_empty, status};

endmodule

`default_nettype wire
